// ===== src/sdcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sdcr_pkg;

    localparam int MAX_VALUES  = 16;
    localparam int VALUE_BITS  = 12;

    localparam int IN_VALUE_W  = 12;
    localparam int REACH_W     = 13;
    localparam int S_TDATA_W   = ((IN_VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((REACH_W + 7) / 8) * 8;

    // reach map covers 0 .. twice the largest member
    localparam int REACH_LIMIT = 2 * ((1 << VALUE_BITS) - 1);
    localparam int MAP_DEPTH   = REACH_LIMIT + 1;
    localparam int MAP_AW      = $clog2(MAP_DEPTH);

    localparam int MEM_AW      = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W       = $clog2(MAX_VALUES + 1);

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [MAP_AW-1:0]     map_addr_t;

    // one word handed from front to back
    typedef struct packed {
        value_t value;
        logic   last;   // closes the set
        logic   keep;   // value is a member to store
        logic   ovf;    // members of this set were dropped
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } fifo_wr_t;

    typedef struct packed {
        logic   full;
        logic   valid;
        entry_t head;
    } fifo_rd_t;

endpackage

`default_nettype wire

// ===== src/sdcr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/sdcr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdcr_front
    import sdcr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_VALUE_W-1:0] s_value,
    input  wire logic                  s_tlast,
    input  wire logic                  fifo_full,
    output fifo_wr_t                   fifo_wr
);

    count_t cnt_reg, cnt_next;
    logic   drop_reg, drop_next;
    logic   accept;
    logic   keep;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign keep     = (cnt_reg < count_t'(MAX_VALUES));

    always_comb begin
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (accept) begin
            if (s_tlast) begin
                cnt_next  = '0;
                drop_next = 1'b0;
            end else if (keep) begin
                cnt_next = cnt_reg + count_t'(1);
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    // a dropped member only travels on when it closes the set
    always_comb begin
        fifo_wr.push        = accept && (keep || s_tlast);
        fifo_wr.entry.value = value_t'(s_value);
        fifo_wr.entry.last  = s_tlast;
        fifo_wr.entry.keep  = keep;
        fifo_wr.entry.ovf   = drop_reg || !keep;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sdcr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdcr_fifo
    import sdcr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire fifo_wr_t wr,
    input  wire logic     pop,
    output fifo_rd_t      rd
);

    entry_t                 buf_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wptr_reg, rptr_reg;
    logic [FIFO_AW:0]       fill_reg, fill_next;
    logic                   do_push, do_pop;

    assign rd.full  = (fill_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign rd.valid = (fill_reg != '0);
    assign rd.head  = buf_reg[rptr_reg];

    assign do_push = wr.push && !rd.full;
    assign do_pop  = pop && rd.valid;

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + (FIFO_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - (FIFO_AW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wptr_reg] <= wr.entry;
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + FIFO_AW'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sdcr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sdcr_back
    import sdcr_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire fifo_rd_t           fifo_rd,
    output logic                    fifo_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [REACH_W-1:0]      m_reach,
    output logic                    m_overflow
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SELF,
        S_DOUBLE,
        S_SUM,
        S_DIFF,
        S_PROBE,
        S_SCAN
    } state_t;

    localparam map_addr_t LIMIT = map_addr_t'(REACH_LIMIT);

    state_t       state_reg, state_next;
    count_t       cnt_reg, cnt_next;
    count_t       idx_reg, idx_next;
    map_addr_t    clr_reg, clr_next;
    map_addr_t    probe_reg, probe_next;
    value_t       cur_reg, cur_next;
    logic         last_reg, last_next;
    logic         ovf_reg, ovf_next;
    logic         ovalid_reg, ovalid_next;
    logic [REACH_W-1:0] reach_reg, reach_next;
    logic         oflag_reg, oflag_next;

    // member store
    logic         mem_we;
    value_t       mem_q;

    // reach map, one bit per value
    logic         map_we;
    map_addr_t    map_waddr;
    logic         map_wdata;
    logic         map_q;

    map_addr_t    cur_ext, a_ext, sum_v, diff_v;
    logic         slot_free;

    assign cur_ext   = map_addr_t'(cur_reg);
    assign a_ext     = map_addr_t'(mem_q);
    assign sum_v     = a_ext + cur_ext;
    assign diff_v    = (a_ext >= cur_ext) ? (a_ext - cur_ext) : (cur_ext - a_ext);
    assign slot_free = !ovalid_reg || m_tready;

    assign m_tvalid   = ovalid_reg;
    assign m_reach    = reach_reg;
    assign m_overflow = oflag_reg;

    sdcr_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_VALUES)
    ) u_members (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (cnt_reg[MEM_AW-1:0]),
        .wr_data (fifo_rd.head.value),
        .rd_addr (idx_next[MEM_AW-1:0]),
        .rd_data (mem_q)
    );

    sdcr_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (map_we),
        .wr_addr (map_waddr),
        .wr_data (map_wdata),
        .rd_addr (probe_next),
        .rd_data (map_q)
    );

    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        clr_next    = clr_reg;
        probe_next  = probe_reg;
        cur_next    = cur_reg;
        last_next   = last_reg;
        ovf_next    = ovf_reg;
        reach_next  = reach_reg;
        oflag_next  = oflag_reg;
        ovalid_next = ovalid_reg && !m_tready;
        fifo_pop    = 1'b0;
        mem_we      = 1'b0;
        map_we      = 1'b0;
        map_waddr   = clr_reg;
        map_wdata   = 1'b1;

        unique case (state_reg)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_wdata = 1'b0;
                if (clr_reg == LIMIT) begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + map_addr_t'(1);
                end
            end
            S_IDLE: begin
                if (fifo_rd.valid) begin
                    fifo_pop  = 1'b1;
                    cur_next  = fifo_rd.head.value;
                    last_next = fifo_rd.head.last;
                    ovf_next  = fifo_rd.head.ovf;
                    idx_next  = '0;
                    if (fifo_rd.head.keep) begin
                        mem_we     = 1'b1;
                        state_next = S_SELF;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_SELF: begin
                map_we     = 1'b1;
                map_waddr  = cur_ext;
                state_next = S_DOUBLE;
            end
            S_DOUBLE: begin
                map_we    = 1'b1;
                map_waddr = cur_ext << 1;
                if (cnt_reg == '0) begin
                    cnt_next   = cnt_reg + count_t'(1);
                    state_next = last_reg ? S_PROBE : S_IDLE;
                end else begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                map_we     = 1'b1;
                map_waddr  = sum_v;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                map_we    = 1'b1;
                map_waddr = diff_v;
                if (idx_reg + count_t'(1) == cnt_reg) begin
                    cnt_next   = cnt_reg + count_t'(1);
                    state_next = last_reg ? S_PROBE : S_IDLE;
                end else begin
                    // read address moves now so the next member is ready
                    idx_next   = idx_reg + count_t'(1);
                    state_next = S_SUM;
                end
            end
            S_PROBE: begin
                probe_next = map_addr_t'(1);
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (map_q && probe_reg != LIMIT) begin
                    probe_next = probe_reg + map_addr_t'(1);
                end else if (slot_free) begin
                    reach_next  = REACH_W'(map_q ? probe_reg : probe_reg - map_addr_t'(1));
                    oflag_next  = ovf_reg;
                    ovalid_next = 1'b1;
                    cnt_next    = '0;
                    clr_next    = '0;
                    state_next  = S_CLEAR;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        last_reg  <= last_next;
        ovf_reg   <= ovf_next;
        idx_reg   <= idx_next;
        probe_reg <= probe_next;
        reach_reg <= reach_next;
        oflag_reg <= oflag_next;
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= '0;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sum_difference_coverage_reach_unit.sv =====
// Sum/difference coverage reach.
// Slave channel: one member per word, s_tlast on the word that closes the set.
// Master channel: one word per set, the largest M with every 1..M equal to a
// member, a sum of two members or the difference of two members; m_tuser is
// set when more than MAX_VALUES members arrived and the extra ones were dropped.
// Members enter a 4-word queue at one per cycle; s_tready falls only when the
// queue is full. The back end takes one member at a time, marking the member,
// its double and its sums and differences with the members ahead of it in a
// one-bit reach map (one write port). After the closing word the map is
// scanned upward from 1, one value per cycle, until the first unmarked value.
// After reset and after each result the back end clears the reach map, one
// entry per cycle, all 2*(2^VALUE_BITS - 1) + 1 entries (8191 here); words
// keep filling the queue meanwhile.
// The result sits in an output register until m_tready; a stalled result
// holds the next scan at its end, and members still queue up in front.
`timescale 1ns / 1ps
`default_nettype none

module sum_difference_coverage_reach_unit
    import sdcr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // value
    input  wire logic                 s_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // reach
    output logic                      m_tuser    // overflow
);

    fifo_wr_t           fifo_wr;
    fifo_rd_t           fifo_rd;
    logic               fifo_pop;
    logic [REACH_W-1:0] reach;

    sdcr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_value   (s_tdata[IN_VALUE_W-1:0]),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_rd.full),
        .fifo_wr   (fifo_wr)
    );

    sdcr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (fifo_wr),
        .pop     (fifo_pop),
        .rd      (fifo_rd)
    );

    sdcr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_rd    (fifo_rd),
        .fifo_pop   (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_reach    (reach),
        .m_overflow (m_tuser)
    );

    assign m_tdata = M_TDATA_W'(reach);

endmodule

`default_nettype wire
